/* sv/skht_pkg.sv */
// shared types, constants and command/status bundles for the string key hash table
package skht_pkg;

    localparam int KEY_BYTES      = 8;
    localparam int TABLE_LOG2_MIN = 6;
    localparam int TABLE_LOG2_MAX = 10;
    localparam int START_LOG2     = 6;
    localparam int SLOT_W         = 10;
    localparam int SLOTS          = 1 << SLOT_W;
    localparam int COUNT_W        = SLOT_W + 1;
    localparam logic [31:0] HASH_MUL = 32'd2654435769;
    localparam int HASH_ROT       = 6;

    typedef enum logic [1:0] {
        OP_LOOKUP = 2'd0,
        OP_ADD    = 2'd1,
        OP_DELETE = 2'd2
    } op_t;

    typedef struct packed {
        logic [1:0]  action;
        logic [63:0] key_bytes;
        logic [3:0]  key_length;
        logic [3:0]  entry_type;
    } req_t;

    typedef struct packed {
        logic              found;
        logic [SLOT_W-1:0] slot;
        logic [3:0]        stored_type;
        logic              refused;
    } res_t;

    typedef struct packed {
        logic        mark;
        logic [3:0]  etype;
        logic [3:0]  len;
        logic [63:0] key;
    } ent_t;

    typedef enum logic [1:0] {
        ADDR_S,
        ADDR_IDX,
        ADDR_GAP
    } addr_sel_t;

    typedef enum logic [2:0] {
        WD_ZERO,
        WD_MARK,
        WD_RETYPE,
        WD_UNTYPE,
        WD_INSERT,
        WD_WK
    } wdata_sel_t;

    typedef enum logic [2:0] {
        FREE_HOLD,
        FREE_DEC,
        FREE_INC,
        FREE_GROW,
        FREE_SHRINK
    } free_op_t;

    typedef enum logic [1:0] {
        LOG2_HOLD,
        LOG2_GROW,
        LOG2_SHRINK
    } log2_op_t;

    typedef enum logic [2:0] {
        RK_MISS,
        RK_FOUND,
        RK_RETYPE,
        RK_INSERT,
        RK_REFUSE,
        RK_DELETED
    } res_kind_t;

    typedef struct packed {
        logic       take_beat;
        logic       wk_req;
        logic       wk_rd;
        logic       hash_start;
        logic       probe_init;
        logic       s_dec;
        logic       n_inc;
        logic       n_clr;
        logic       idx_inc;
        logic       idx_clr;
        logic       gap_load;
        logic       rd_en;
        addr_sel_t  rd_sel;
        logic       rd_other;
        logic       wr_en;
        addr_sel_t  wr_addr;
        wdata_sel_t wr_data;
        logic       wr_other;
        free_op_t   free_op;
        log2_op_t   log2_op;
        logic       bank_flip;
        logic       res_load;
        res_kind_t  res_kind;
        logic       out_load;
    } cmd_t;

    typedef struct packed {
        op_t  op;
        logic hash_done;
        logic rd_free;
        logic rd_match;
        logic rd_mark;
        logic n_last;
        logic n_full;
        logic idx_last;
        logic idx_old_last;
        logic free_zero;
        logic at_max;
        logic shrink;
        logic gap_stay;
        logic out_free;
    } status_t;

endpackage

/* sv/string_key_hash_table_top.sv */
// top level of the string key hash table
//
//  channel   ports                          direction  payload
//  request   s_valid s_ready s_data         in         req_t: action, key, length, type
//  result    m_valid m_ready m_data         out        res_t: found, slot, type, refused
//  config    cfg_wr_en cfg_wr_data          in         start_log2, 4 bits
//
//  one request at a time; the hash walks the key bytes, and each probe step reads a slot, then evaluates it
//  growing or shrinking sweeps the new table, then reprobes every old entry from one bank port
//  gap closing after a delete rehashes each displaced entry it visits
//  after reset or a config write the table is cleared slot by slot, s_ready low
//  the result register frees the request side while a result beat waits on m_ready
module string_key_hash_table_top (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  skht_pkg::req_t   s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output skht_pkg::res_t   m_data,
    input  logic             cfg_wr_en,
    input  logic [3:0]       cfg_wr_data
);
    import skht_pkg::*;

    cmd_t    cmd;
    status_t st;

    skht_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .cfg_wr_en (cfg_wr_en),
        .st        (st),
        .cmd       (cmd)
    );

    skht_datapath u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_data      (s_data),
        .cmd         (cmd),
        .st          (st),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

endmodule

/* sv/skht_hash.sv */
// key hash: rotate-add over the key bytes, then multiplicative slot selection
module skht_hash (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic [63:0]                key,
    input  logic [3:0]                 len,
    input  logic [3:0]                 log2,
    output logic                       done,
    output logic [skht_pkg::SLOT_W-1:0] home
);
    import skht_pkg::*;

    typedef enum logic [1:0] {
        H_IDLE,
        H_ACC,
        H_MUL,
        H_DONE
    } phase_t;

    phase_t      phase_reg;
    logic [31:0] h_reg;
    logic [3:0]  cnt_reg;
    logic [31:0] prod_reg;
    logic [7:0]  cur_byte;
    logic [5:0]  shamt;

    assign cur_byte = key[{cnt_reg[2:0], 3'b000} +: 8];
    assign shamt    = 6'd32 - {2'b00, log2};
    assign done     = (phase_reg == H_DONE);
    assign home     = SLOT_W'(prod_reg >> shamt);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= H_IDLE;
        end else if (start) begin
            phase_reg <= H_ACC;
            h_reg     <= '0;
            cnt_reg   <= '0;
        end else begin
            case (phase_reg)
                H_ACC: begin
                    if (cnt_reg == len) begin
                        phase_reg <= H_MUL;
                    end else begin
                        h_reg   <= {h_reg[31-HASH_ROT:0], h_reg[31:32-HASH_ROT]}
                                   + {24'h000000, cur_byte};
                        cnt_reg <= cnt_reg + 4'd1;
                    end
                end
                H_MUL: begin
                    prod_reg  <= h_reg * HASH_MUL;
                    phase_reg <= H_DONE;
                end
                default: ;
            endcase
        end
    end

endmodule

/* sv/skht_datapath.sv */
// table banks, probe and sweep registers, sizing and result registers
module skht_datapath (
    input  logic              aclk,
    input  logic              aresetn,
    input  skht_pkg::req_t    s_data,
    input  skht_pkg::cmd_t    cmd,
    output skht_pkg::status_t st,
    input  logic              cfg_wr_en,
    input  logic [3:0]        cfg_wr_data,
    output logic              m_valid,
    input  logic              m_ready,
    output skht_pkg::res_t    m_data
);
    import skht_pkg::*;

    logic [3:0]         table_log2_reg;
    logic [3:0]         old_log2_reg;
    logic [COUNT_W-1:0] free_count_reg;
    logic               cur_bank_reg;
    op_t                op_reg;
    logic [63:0]        rq_key_reg;
    logic [3:0]         rq_len_reg;
    logic [3:0]         rq_type_reg;
    ent_t               wk_reg;
    logic [SLOT_W-1:0]  s_reg;
    logic [SLOT_W-1:0]  idx_reg;
    logic [SLOT_W-1:0]  gap_reg;
    logic [COUNT_W-1:0] n_reg;
    ent_t               bank0_mem [SLOTS];
    ent_t               bank1_mem [SLOTS];
    ent_t               rd0_reg;
    ent_t               rd1_reg;
    logic               rd_bank_reg;
    res_t               res_reg;
    res_t               out_reg;
    logic               m_valid_reg;

    ent_t               rd_ent;
    ent_t               wd;
    logic [SLOT_W-1:0]  wr_addr;
    logic [SLOT_W-1:0]  rd_addr;
    logic               wr_bank;
    logic               rd_bank;
    logic [COUNT_W-1:0] size;
    logic [COUNT_W-1:0] old_size;
    logic [SLOT_W-1:0]  slot_mask;
    logic [3:0]         len_n;
    logic [63:0]        key_n;
    op_t                op_n;
    logic [3:0]         cfg_log2;
    logic [COUNT_W-1:0] free_plus;
    res_t               res_next;
    logic               hash_done;
    logic [SLOT_W-1:0]  home;

    function automatic logic [COUNT_W-1:0] free_init(input logic [3:0] lg);
        logic [COUNT_W-1:0] sz;
        sz = COUNT_W'(1) << lg;
        return sz - (sz >> 3);
    endfunction

    skht_hash u_hash (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.hash_start),
        .key     (wk_reg.key),
        .len     (wk_reg.len),
        .log2    (table_log2_reg),
        .done    (hash_done),
        .home    (home)
    );

    assign size      = COUNT_W'(1) << table_log2_reg;
    assign old_size  = COUNT_W'(1) << old_log2_reg;
    assign slot_mask = SLOT_W'(size - COUNT_W'(1));
    assign free_plus = free_count_reg + COUNT_W'(1);
    assign rd_ent    = rd_bank_reg ? rd1_reg : rd0_reg;
    assign wr_bank   = cur_bank_reg ^ cmd.wr_other;
    assign rd_bank   = cur_bank_reg ^ cmd.rd_other;

    // incoming beat, normalized
    always_comb begin
        len_n = (s_data.key_length > 4'(KEY_BYTES)) ? 4'(KEY_BYTES) : s_data.key_length;
        for (int i = 0; i < 8; i++) begin
            key_n[8*i +: 8] = (i < int'(len_n)) ? s_data.key_bytes[8*i +: 8] : 8'h00;
        end
        case (op_t'(s_data.action))
            OP_ADD:    op_n = (s_data.entry_type == 4'd0) ? OP_LOOKUP : OP_ADD;
            OP_DELETE: op_n = OP_DELETE;
            default:   op_n = OP_LOOKUP;
        endcase
    end

    always_comb begin
        if (cfg_wr_data < 4'(TABLE_LOG2_MIN)) begin
            cfg_log2 = 4'(TABLE_LOG2_MIN);
        end else if (cfg_wr_data > 4'(TABLE_LOG2_MAX)) begin
            cfg_log2 = 4'(TABLE_LOG2_MAX);
        end else begin
            cfg_log2 = cfg_wr_data;
        end
    end

    always_comb begin
        case (cmd.wr_addr)
            ADDR_S:   wr_addr = s_reg;
            ADDR_GAP: wr_addr = gap_reg;
            default:  wr_addr = idx_reg;
        endcase
        case (cmd.rd_sel)
            ADDR_IDX: rd_addr = idx_reg;
            default:  rd_addr = s_reg;
        endcase
    end

    always_comb begin
        wd = rd_ent;
        case (cmd.wr_data)
            WD_MARK:   wd.mark = 1'b1;
            WD_RETYPE: wd.etype = rq_type_reg;
            WD_UNTYPE: wd.etype = 4'd0;
            WD_INSERT: begin
                wd.etype = rq_type_reg;
                wd.len   = rq_len_reg;
                wd.key   = rq_key_reg;
            end
            WD_WK:     wd = wk_reg;
            default:   wd = '0;
        endcase
    end

    always_comb begin
        res_next = '0;
        case (cmd.res_kind)
            RK_FOUND: begin
                res_next.found       = 1'b1;
                res_next.slot        = s_reg;
                res_next.stored_type = rd_ent.etype;
            end
            RK_RETYPE: begin
                res_next.found       = 1'b1;
                res_next.slot        = s_reg;
                res_next.stored_type = rq_type_reg;
            end
            RK_INSERT: begin
                res_next.slot        = s_reg;
                res_next.stored_type = rq_type_reg;
            end
            RK_REFUSE:  res_next.refused = 1'b1;
            RK_DELETED: res_next.found   = 1'b1;
            default: ;
        endcase
    end

    // two banks: the live table and the target of a resize
    always_ff @(posedge aclk) begin
        if (cmd.wr_en && !wr_bank) begin
            bank0_mem[wr_addr] <= wd;
        end
        if (cmd.rd_en && !rd_bank) begin
            rd0_reg <= bank0_mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.wr_en && wr_bank) begin
            bank1_mem[wr_addr] <= wd;
        end
        if (cmd.rd_en && rd_bank) begin
            rd1_reg <= bank1_mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            table_log2_reg <= 4'(START_LOG2);
            free_count_reg <= free_init(4'(START_LOG2));
            cur_bank_reg   <= 1'b0;
            idx_reg        <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                table_log2_reg <= cfg_log2;
                free_count_reg <= free_init(cfg_log2);
                idx_reg        <= '0;
            end else begin
                case (cmd.log2_op)
                    LOG2_GROW:   table_log2_reg <= table_log2_reg + 4'd1;
                    LOG2_SHRINK: table_log2_reg <= table_log2_reg - 4'd1;
                    default: ;
                endcase
                case (cmd.free_op)
                    FREE_DEC:    free_count_reg <= free_count_reg - COUNT_W'(1);
                    FREE_INC:    free_count_reg <= free_plus;
                    FREE_GROW:   free_count_reg <= size;
                    FREE_SHRINK: free_count_reg <= free_plus - (size >> 1);
                    default: ;
                endcase
                if (cmd.idx_clr) begin
                    idx_reg <= '0;
                end else if (cmd.idx_inc) begin
                    idx_reg <= idx_reg + SLOT_W'(1);
                end
            end
            if (cmd.bank_flip) begin
                cur_bank_reg <= ~cur_bank_reg;
            end
            if (cmd.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.take_beat) begin
            rq_key_reg  <= key_n;
            rq_len_reg  <= len_n;
            rq_type_reg <= s_data.entry_type;
            op_reg      <= op_n;
            wk_reg      <= '{mark: 1'b0, etype: s_data.entry_type, len: len_n, key: key_n};
        end else if (cmd.wk_req) begin
            wk_reg <= '{mark: 1'b0, etype: rq_type_reg, len: rq_len_reg, key: rq_key_reg};
        end else if (cmd.wk_rd) begin
            wk_reg <= rd_ent;
        end
        if (cmd.log2_op != LOG2_HOLD) begin
            old_log2_reg <= table_log2_reg;
        end
        if (cmd.probe_init) begin
            s_reg <= home;
            n_reg <= '0;
        end else begin
            if (cmd.s_dec) begin
                s_reg <= (s_reg == '0) ? slot_mask : s_reg - SLOT_W'(1);
            end
            if (cmd.n_clr) begin
                n_reg <= '0;
            end else if (cmd.n_inc) begin
                n_reg <= n_reg + COUNT_W'(1);
            end
        end
        if (cmd.gap_load) begin
            gap_reg <= s_reg;
        end
        if (cmd.rd_en) begin
            rd_bank_reg <= rd_bank;
        end
        if (cmd.res_load) begin
            res_reg <= res_next;
        end
        if (cmd.out_load) begin
            out_reg <= res_reg;
        end
    end

    always_comb begin
        st.op           = op_reg;
        st.hash_done    = hash_done;
        st.rd_free      = (rd_ent.etype == 4'd0);
        st.rd_match     = (rd_ent.etype != 4'd0) && (rd_ent.len == wk_reg.len)
                          && (rd_ent.key == wk_reg.key);
        st.rd_mark      = rd_ent.mark;
        st.n_last       = (n_reg == size - COUNT_W'(1));
        st.n_full       = (n_reg == size);
        st.idx_last     = ({1'b0, idx_reg} == size - COUNT_W'(1));
        st.idx_old_last = ({1'b0, idx_reg} == old_size - COUNT_W'(1));
        st.free_zero    = (free_count_reg == '0);
        st.at_max       = (table_log2_reg >= 4'(TABLE_LOG2_MAX));
        st.shrink       = (table_log2_reg > 4'(TABLE_LOG2_MIN))
                          && (free_plus == size - (size >> 2));
        // home of the entry at s lies cyclically in [s, gap): it must stay
        st.gap_stay     = ((s_reg <= home) && (home < gap_reg))
                          || ((gap_reg < s_reg) && ((home < gap_reg) || (s_reg <= home)));
        st.out_free     = !m_valid_reg || m_ready;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

    a_out_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!m_valid_reg || m_ready))
        else $error("result loaded over an untaken beat");

endmodule

/* sv/skht_ctrl.sv */
// sequencer for probe, insert, delete, gap closing, resize and clearing
module skht_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic              cfg_wr_en,
    input  skht_pkg::status_t st,
    output skht_pkg::cmd_t    cmd
);
    import skht_pkg::*;

    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_HASH,
        ST_PRD,
        ST_PEV,
        ST_POST,
        ST_RH_START,
        ST_RH_CLR,
        ST_RH_RD,
        ST_RH_CHK,
        ST_RH_NEXT,
        ST_RH_END,
        ST_GAP_CLR,
        ST_GAP_STEP,
        ST_GAP_RD,
        ST_GAP_EV,
        ST_GAP_HASH,
        ST_GAP_CMP,
        ST_FINISH
    } state_t;

    state_t state_reg, state_next;
    logic   in_rehash_reg, in_rehash_next;
    logic   grow_reg, grow_next;
    logic   hit_reg, hit_next;
    logic   pfree_reg, pfree_next;

    always_comb begin
        state_next     = state_reg;
        in_rehash_next = in_rehash_reg;
        grow_next      = grow_reg;
        hit_next       = hit_reg;
        pfree_next     = pfree_reg;
        cmd            = '0;
        s_ready        = 1'b0;
        case (state_reg)
            ST_CLEAR: begin
                cmd.wr_en   = 1'b1;
                cmd.wr_addr = ADDR_IDX;
                cmd.wr_data = WD_ZERO;
                if (st.idx_last) begin
                    cmd.idx_clr = 1'b1;
                    state_next  = ST_IDLE;
                end else begin
                    cmd.idx_inc = 1'b1;
                end
            end
            ST_IDLE: begin
                s_ready = !cfg_wr_en;
                if (s_valid && !cfg_wr_en) begin
                    cmd.take_beat  = 1'b1;
                    cmd.hash_start = 1'b1;
                    state_next     = ST_HASH;
                end
            end
            ST_HASH: begin
                if (st.hash_done) begin
                    cmd.probe_init = 1'b1;
                    state_next     = ST_PRD;
                end
            end
            ST_PRD: begin
                cmd.rd_en    = 1'b1;
                cmd.rd_sel   = ADDR_S;
                cmd.rd_other = in_rehash_reg;
                state_next   = ST_PEV;
            end
            ST_PEV: begin
                if (st.rd_free) begin
                    hit_next   = 1'b0;
                    pfree_next = 1'b1;
                    state_next = ST_POST;
                end else if (st.rd_match) begin
                    hit_next   = 1'b1;
                    pfree_next = 1'b0;
                    state_next = ST_POST;
                end else begin
                    if (st.op == OP_ADD || in_rehash_reg) begin
                        cmd.wr_en    = 1'b1;
                        cmd.wr_addr  = ADDR_S;
                        cmd.wr_data  = WD_MARK;
                        cmd.wr_other = in_rehash_reg;
                    end
                    if (st.n_last) begin
                        hit_next   = 1'b0;
                        pfree_next = 1'b0;
                        state_next = ST_POST;
                    end else begin
                        cmd.s_dec  = 1'b1;
                        cmd.n_inc  = 1'b1;
                        state_next = ST_PRD;
                    end
                end
            end
            ST_POST: begin
                if (in_rehash_reg) begin
                    if (pfree_reg) begin
                        cmd.wr_en    = 1'b1;
                        cmd.wr_addr  = ADDR_S;
                        cmd.wr_data  = WD_WK;
                        cmd.wr_other = 1'b1;
                    end
                    state_next = ST_RH_NEXT;
                end else begin
                    cmd.res_load = 1'b1;
                    state_next   = ST_FINISH;
                    case (st.op)
                        OP_ADD: begin
                            if (hit_reg) begin
                                cmd.wr_en    = 1'b1;
                                cmd.wr_addr  = ADDR_S;
                                cmd.wr_data  = WD_RETYPE;
                                cmd.res_kind = RK_RETYPE;
                            end else if (!pfree_reg) begin
                                cmd.res_kind = RK_REFUSE;
                            end else if (st.free_zero) begin
                                if (st.at_max) begin
                                    cmd.res_kind = RK_REFUSE;
                                end else begin
                                    cmd.res_load = 1'b0;
                                    cmd.free_op  = FREE_GROW;
                                    grow_next    = 1'b1;
                                    state_next   = ST_RH_START;
                                end
                            end else begin
                                cmd.free_op  = FREE_DEC;
                                cmd.wr_en    = 1'b1;
                                cmd.wr_addr  = ADDR_S;
                                cmd.wr_data  = WD_INSERT;
                                cmd.res_kind = RK_INSERT;
                            end
                        end
                        OP_DELETE: begin
                            if (!hit_reg) begin
                                cmd.res_kind = RK_MISS;
                            end else begin
                                cmd.res_kind = RK_DELETED;
                                if (st.shrink) begin
                                    cmd.free_op = FREE_SHRINK;
                                    cmd.wr_en   = 1'b1;
                                    cmd.wr_addr = ADDR_S;
                                    cmd.wr_data = WD_UNTYPE;
                                    grow_next   = 1'b0;
                                    state_next  = ST_RH_START;
                                end else if (st.rd_mark) begin
                                    cmd.free_op  = FREE_INC;
                                    cmd.gap_load = 1'b1;
                                    state_next   = ST_GAP_CLR;
                                end else begin
                                    cmd.free_op = FREE_INC;
                                    cmd.wr_en   = 1'b1;
                                    cmd.wr_addr = ADDR_S;
                                    cmd.wr_data = WD_UNTYPE;
                                end
                            end
                        end
                        default: begin
                            cmd.res_kind = hit_reg ? RK_FOUND : RK_MISS;
                        end
                    endcase
                end
            end
            ST_RH_START: begin
                cmd.log2_op    = grow_reg ? LOG2_GROW : LOG2_SHRINK;
                cmd.idx_clr    = 1'b1;
                in_rehash_next = 1'b1;
                state_next     = ST_RH_CLR;
            end
            ST_RH_CLR: begin
                cmd.wr_en    = 1'b1;
                cmd.wr_addr  = ADDR_IDX;
                cmd.wr_data  = WD_ZERO;
                cmd.wr_other = 1'b1;
                if (st.idx_last) begin
                    cmd.idx_clr = 1'b1;
                    state_next  = ST_RH_RD;
                end else begin
                    cmd.idx_inc = 1'b1;
                end
            end
            ST_RH_RD: begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = ADDR_IDX;
                state_next = ST_RH_CHK;
            end
            ST_RH_CHK: begin
                if (st.rd_free) begin
                    state_next = ST_RH_NEXT;
                end else begin
                    cmd.wk_rd      = 1'b1;
                    cmd.hash_start = 1'b1;
                    state_next     = ST_HASH;
                end
            end
            ST_RH_NEXT: begin
                if (st.idx_old_last) begin
                    state_next = ST_RH_END;
                end else begin
                    cmd.idx_inc = 1'b1;
                    state_next  = ST_RH_RD;
                end
            end
            ST_RH_END: begin
                cmd.bank_flip  = 1'b1;
                in_rehash_next = 1'b0;
                if (st.op == OP_ADD) begin
                    cmd.wk_req     = 1'b1;
                    cmd.hash_start = 1'b1;
                    state_next     = ST_HASH;
                end else begin
                    state_next = ST_FINISH;
                end
            end
            ST_GAP_CLR: begin
                cmd.wr_en   = 1'b1;
                cmd.wr_addr = ADDR_GAP;
                cmd.wr_data = WD_ZERO;
                cmd.n_clr   = 1'b1;
                state_next  = ST_GAP_STEP;
            end
            ST_GAP_STEP: begin
                if (st.n_full) begin
                    state_next = ST_FINISH;
                end else begin
                    cmd.s_dec  = 1'b1;
                    state_next = ST_GAP_RD;
                end
            end
            ST_GAP_RD: begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = ADDR_S;
                state_next = ST_GAP_EV;
            end
            ST_GAP_EV: begin
                if (st.rd_free) begin
                    state_next = ST_FINISH;
                end else begin
                    cmd.wk_rd      = 1'b1;
                    cmd.hash_start = 1'b1;
                    state_next     = ST_GAP_HASH;
                end
            end
            ST_GAP_HASH: begin
                if (st.hash_done) begin
                    state_next = ST_GAP_CMP;
                end
            end
            ST_GAP_CMP: begin
                if (st.gap_stay) begin
                    cmd.n_inc  = 1'b1;
                    state_next = ST_GAP_STEP;
                end else begin
                    cmd.wr_en    = 1'b1;
                    cmd.wr_addr  = ADDR_GAP;
                    cmd.wr_data  = WD_WK;
                    cmd.gap_load = 1'b1;
                    state_next   = ST_GAP_CLR;
                end
            end
            ST_FINISH: begin
                if (st.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_CLEAR;
        endcase
        // a register write empties the table
        if (cfg_wr_en) begin
            state_next     = ST_CLEAR;
            in_rehash_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            in_rehash_reg <= 1'b0;
            grow_reg      <= 1'b0;
            hit_reg       <= 1'b0;
            pfree_reg     <= 1'b0;
        end else begin
            state_reg     <= state_next;
            in_rehash_reg <= in_rehash_next;
            grow_reg      <= grow_next;
            hit_reg       <= hit_next;
            pfree_reg     <= pfree_next;
        end
    end

    a_no_rd_wr: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.rd_en && cmd.wr_en))
        else $error("bank read and write issued together");

    a_eval_after_read: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_PEV) |-> ($past(state_reg) == ST_PRD))
        else $error("probe evaluated without a read");

    a_rehash_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        in_rehash_reg |-> (state_reg != ST_IDLE && state_reg != ST_FINISH))
        else $error("resize left unfinished");

endmodule
